/* rtl/gif_lzw_pixel_decoder_top_defines.svh */
// assertion helpers for the checker file
`ifndef GIF_LZW_PIXEL_DECODER_TOP_DEFINES_SVH
`define GIF_LZW_PIXEL_DECODER_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet while in reset
`define GLPD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glpd check failed");

// next-cycle implication, clocked on clk, quiet while in reset
`define GLPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glpd check failed");

`endif

/* rtl/glpd_pkg.sv */
`timescale 1ns / 1ps
package glpd_pkg;

    localparam int TABLE_AW          = 12;
    localparam int TABLE_DEPTH       = 1 << TABLE_AW;
    localparam int MAX_CODE_BITS_DEF = 12;
    localparam int CFG_IW            = 3;

    // request codes
    localparam logic [1:0] REQ_FEED    = 2'd0;
    localparam logic [1:0] REQ_PULL    = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;
    localparam logic [1:0] REQ_BAD     = 2'd3;

    // register indexes
    localparam logic [CFG_IW-1:0] CFG_LEFT       = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_TOP        = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_WIDTH      = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_HEIGHT     = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_INTERLACED = 3'd4;

    typedef enum logic [2:0] {
        ST_TAKEN,
        ST_REFUSED,
        ST_PIXEL,
        ST_NEED_BYTE,
        ST_DONE
    } status_t;

    typedef enum logic [1:0] {
        PH_SIZE,
        PH_LENGTH,
        PH_DATA,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PULL,
        S_SETTLE,
        S_PLEN,
        S_LEN,
        S_WALK,
        S_TAIL
    } state_t;

    typedef struct packed {
        logic [TABLE_AW-1:0] base;
        logic [7:0]          ch;
        logic [TABLE_AW:0]   len;
    } entry_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [3:0]  step;
    } cursor_t;

    // stored length, forced into 1..TABLE_DEPTH
    function automatic logic [TABLE_AW:0] clamp_len(input logic [TABLE_AW:0] len);
        logic [TABLE_AW:0] r;
        r = len;
        if (len == '0)
            r = (TABLE_AW+1)'(1);
        else if (len > (TABLE_AW+1)'(TABLE_DEPTH))
            r = (TABLE_AW+1)'(TABLE_DEPTH);
        return r;
    endfunction

endpackage

/* rtl/glpd_req_if.sv */
`timescale 1ns / 1ps
interface glpd_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] data_byte;

    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

/* rtl/glpd_rsp_if.sv */
`timescale 1ns / 1ps
interface glpd_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [7:0]  color_index;

    modport source (output valid, output status, output pixel_x, output pixel_y,
                    output color_index, input ready);
    modport sink (input valid, input status, input pixel_x, input pixel_y,
                  input color_index, output ready);
endinterface

/* rtl/glpd_cfg_if.sv */
`timescale 1ns / 1ps
interface glpd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/gif_lzw_pixel_decoder_top.sv */
`timescale 1ns / 1ps
// A feed, restart or refused transaction answers in the cycle after it is taken; a pull
// that yields a pixel passes the S_PULL state, then the registered answer. Requests are
// taken only in S_IDLE, so a pixel is through before the next pull; a code extending a
// string runs S_SETTLE, S_PLEN, S_LEN, S_WALK, S_TAIL, the walk reading one entry per cycle.
// Reset clears all control state at once; the table memories need no clearing pass.
module gif_lzw_pixel_decoder_top import glpd_pkg::*; #(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    glpd_req_if.sink  req,
    glpd_rsp_if.source rsp,
    glpd_cfg_if.sink  cfg
);

    localparam int AW = TABLE_AW;

    state_t state_reg, state_next;

    logic [15:0] left_reg, top_reg, width_reg, height_reg;
    logic        interl_reg;

    logic [23:0] bb_reg, bb_next;
    logic [4:0]  bits_reg, bits_next;
    logic [7:0]  sub_reg, sub_next;
    phase_t      phase_reg, phase_next;
    logic [3:0]  root_reg, root_next;
    logic [3:0]  cw_reg, cw_next;
    logic [AW:0] nf_reg, nf_next;
    logic        full_reg, full_next;
    logic [AW-1:0] prev_reg, prev_next;
    logic        havep_reg, havep_next;
    logic [AW:0] pcount_reg, pcount_next;
    logic [AW:0] pidx_reg, pidx_next;
    cursor_t     cur_reg, cur_next;

    logic [AW-1:0] code_reg, code_next;
    logic [AW-1:0] tgt_reg, tgt_next;
    logic          kwk_reg, kwk_next;
    logic [AW:0]   plen_reg, plen_next;
    logic [AW:0]   n_reg, n_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] c_reg, c_next;
    logic [7:0]    first_reg, first_next;

    logic        ov_reg, ov_next;
    status_t     ost_reg, ost_next;
    logic [15:0] opx_reg, opx_next, opy_reg, opy_next;
    logic [7:0]  oci_reg, oci_next;

    logic          ct_we;
    logic [AW-1:0] ct_waddr, ct_raddr;
    entry_t        ct_wdata, ct_rdata;
    logic          sb_we;
    logic [AW-1:0] sb_waddr;
    logic [7:0]    sb_wdata, sb_rdata;

    cursor_t     cur_adv;
    logic [15:0] cur_px, cur_py;

    logic          in_acc;
    logic          pending;
    logic          settle_go;
    logic [AW:0]   cc;
    logic [23:0]   code_bits;
    logic [AW-1:0] code_w;
    logic          is_clear, is_end, is_expand;
    logic [AW:0]   pidx_inc;
    logic [3:0]    root_new;
    logic [AW:0]   nf_inc;
    logic [3:0]    cw_inc;
    logic [7:0]    walk_ch;

    // code table and string buffer
    glpd_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_DEPTH)) u_code_table (
        .clk   (clk),
        .we    (ct_we),
        .waddr (ct_waddr),
        .wdata (ct_wdata),
        .raddr (ct_raddr),
        .rdata (ct_rdata)
    );

    glpd_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_string_buf (
        .clk   (clk),
        .we    (sb_we),
        .waddr (sb_waddr),
        .wdata (sb_wdata),
        .raddr (pidx_reg[AW-1:0]),
        .rdata (sb_rdata)
    );

    glpd_cursor u_cursor (
        .cur          (cur_reg),
        .left_edge    (left_reg),
        .top_edge     (top_reg),
        .image_width  (width_reg),
        .image_height (height_reg),
        .nxt          (cur_adv),
        .pixel_x      (cur_px),
        .pixel_y      (cur_py)
    );

    // handshakes
    assign req.ready = (state_reg == S_IDLE) && (!ov_reg || rsp.ready);
    assign in_acc    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid       = ov_reg;
    assign rsp.status      = ost_reg;
    assign rsp.pixel_x     = opx_reg;
    assign rsp.pixel_y     = opy_reg;
    assign rsp.color_index = oci_reg;

    // decode-side conditions
    always_comb
    begin
        cc        = (AW+1)'(1) << root_reg;
        pending   = pidx_reg < pcount_reg;
        settle_go = (phase_reg == PH_LENGTH || phase_reg == PH_DATA) && !pending
                    && cw_reg != 4'd0 && bits_reg >= 5'(cw_reg);
        code_bits = bb_reg & ((24'd1 << cw_reg) - 24'd1);
        code_w    = code_bits[AW-1:0];
        is_clear  = {1'b0, code_w} == cc;
        is_end    = {1'b0, code_w} == cc + (AW+1)'(1);
        is_expand = havep_reg && !is_clear && !is_end;
        pidx_inc  = pidx_reg + (AW+1)'(1);
        root_new  = (req.data_byte < 8'd2) ? 4'd2 :
                    (req.data_byte > 8'd8) ? 4'd8 : req.data_byte[3:0];
        nf_inc    = nf_reg + (AW+1)'(1);
        cw_inc    = (nf_inc == ((AW+1)'(1) << cw_reg)) ? cw_reg + 4'd1 : cw_reg;
        walk_ch   = ({1'b0, c_reg} < cc) ? c_reg[7:0] : ct_rdata.ch;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (req.req_type == REQ_PULL && pending)
                        state_next = S_PULL;
                    else if (req.req_type == REQ_FEED && phase_reg != PH_DONE && !pending)
                        state_next = S_SETTLE;
                end
            end
            S_PULL:
                state_next = (pidx_inc >= pcount_reg) ? S_SETTLE : S_IDLE;
            S_SETTLE:
            begin
                if (!settle_go)
                    state_next = S_IDLE;
                else if (is_expand)
                    state_next = S_PLEN;
            end
            S_PLEN:
                state_next = S_LEN;
            S_LEN:
                state_next = S_WALK;
            S_WALK:
                state_next = (i_reg == '0) ? S_TAIL : S_WALK;
            S_TAIL:
                state_next = S_SETTLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        bb_next     = bb_reg;
        bits_next   = bits_reg;
        sub_next    = sub_reg;
        phase_next  = phase_reg;
        root_next   = root_reg;
        cw_next     = cw_reg;
        nf_next     = nf_reg;
        full_next   = full_reg;
        prev_next   = prev_reg;
        havep_next  = havep_reg;
        pcount_next = pcount_reg;
        pidx_next   = pidx_reg;
        cur_next    = cur_reg;
        code_next   = code_reg;
        tgt_next    = tgt_reg;
        kwk_next    = kwk_reg;
        plen_next   = plen_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        c_next      = c_reg;
        first_next  = first_reg;
        ov_next     = ov_reg && !rsp.ready;
        ost_next    = ost_reg;
        opx_next    = opx_reg;
        opy_next    = opy_reg;
        oci_next    = oci_reg;
        ct_we       = 1'b0;
        ct_waddr    = nf_reg[AW-1:0];
        ct_wdata    = '{base: prev_reg, ch: first_reg, len: '0};
        ct_raddr    = prev_reg;
        sb_we       = 1'b0;
        sb_waddr    = '0;
        sb_wdata    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    opx_next = '0;
                    opy_next = '0;
                    oci_next = '0;
                    case (req.req_type)
                        REQ_RESTART:
                        begin
                            ov_next     = 1'b1;
                            ost_next    = ST_TAKEN;
                            bb_next     = '0;
                            bits_next   = '0;
                            sub_next    = '0;
                            phase_next  = PH_SIZE;
                            root_next   = '0;
                            cw_next     = '0;
                            nf_next     = '0;
                            full_next   = 1'b0;
                            prev_next   = '0;
                            havep_next  = 1'b0;
                            pcount_next = '0;
                            pidx_next   = '0;
                            cur_next    = '{x: '0, y: '0, step: 4'd1};
                        end
                        REQ_PULL:
                        begin
                            if (!pending)
                            begin
                                ov_next  = 1'b1;
                                ost_next = (phase_reg == PH_DONE) ? ST_DONE : ST_NEED_BYTE;
                            end
                        end
                        REQ_FEED:
                        begin
                            ov_next = 1'b1;
                            if (phase_reg == PH_DONE)
                                ost_next = ST_DONE;
                            else if (pending)
                                ost_next = ST_REFUSED;
                            else
                            begin
                                ost_next = ST_TAKEN;
                                case (phase_reg)
                                    PH_SIZE:
                                    begin
                                        root_next  = root_new;
                                        nf_next    = ((AW+1)'(1) << root_new) + (AW+1)'(2);
                                        cw_next    = root_new + 4'd1;
                                        full_next  = 1'b0;
                                        havep_next = 1'b0;
                                        bb_next    = '0;
                                        bits_next  = '0;
                                        sub_next   = '0;
                                        cur_next   = '{x: '0, y: '0,
                                                       step: interl_reg ? 4'd8 : 4'd1};
                                        phase_next = PH_LENGTH;
                                    end
                                    PH_LENGTH:
                                    begin
                                        if (req.data_byte == 8'd0)
                                            phase_next = PH_DONE;
                                        else
                                        begin
                                            sub_next   = req.data_byte;
                                            phase_next = PH_DATA;
                                        end
                                    end
                                    default:
                                    begin
                                        if (bits_reg <= 5'd16)
                                        begin
                                            bb_next   = bb_reg | (24'(req.data_byte) << bits_reg);
                                            bits_next = bits_reg + 5'd8;
                                        end
                                        sub_next = sub_reg - 8'd1;
                                        if (sub_reg == 8'd1)
                                            phase_next = PH_LENGTH;
                                    end
                                endcase
                            end
                        end
                        default:
                        begin
                            ov_next  = 1'b1;
                            ost_next = ST_REFUSED;
                        end
                    endcase
                end
            end
            S_PULL:
            begin
                ov_next  = 1'b1;
                ost_next = ST_PIXEL;
                opx_next = cur_px;
                opy_next = cur_py;
                oci_next = sb_rdata;
                cur_next = cur_adv;
                if (pidx_inc >= pcount_reg)
                begin
                    pidx_next   = '0;
                    pcount_next = '0;
                end
                else
                    pidx_next = pidx_inc;
            end
            S_SETTLE:
            begin
                if (settle_go)
                begin
                    bb_next   = bb_reg >> cw_reg;
                    bits_next = bits_reg - 5'(cw_reg);
                    if (is_clear)
                    begin
                        nf_next    = cc + (AW+1)'(2);
                        cw_next    = root_reg + 4'd1;
                        full_next  = 1'b0;
                        havep_next = 1'b0;
                    end
                    else if (is_end)
                    begin
                        phase_next = PH_DONE;
                        bb_next    = '0;
                        bits_next  = '0;
                    end
                    else if (!havep_reg)
                    begin
                        // first code of a string run: roots only
                        if ({1'b0, code_w} < cc)
                        begin
                            sb_we       = 1'b1;
                            sb_waddr    = '0;
                            sb_wdata    = code_w[7:0];
                            pcount_next = (AW+1)'(1);
                            pidx_next   = '0;
                            prev_next   = code_w;
                            havep_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        // fetch previous entry for its length
                        code_next = code_w;
                        kwk_next  = {1'b0, code_w} >= nf_reg;
                        tgt_next  = ({1'b0, code_w} >= nf_reg) ? prev_reg : code_w;
                        ct_raddr  = prev_reg;
                    end
                end
            end
            S_PLEN:
            begin
                plen_next = ({1'b0, prev_reg} < cc) ? (AW+1)'(1) : clamp_len(ct_rdata.len);
                ct_raddr  = tgt_reg;
            end
            S_LEN:
            begin
                n_next   = ({1'b0, tgt_reg} < cc) ? (AW+1)'(1) : clamp_len(ct_rdata.len);
                i_next   = AW'((({1'b0, tgt_reg} < cc) ? (AW+1)'(1) :
                               clamp_len(ct_rdata.len)) - (AW+1)'(1));
                c_next   = tgt_reg;
                ct_raddr = tgt_reg;
            end
            S_WALK:
            begin
                // write one character from the end, follow the chain
                sb_we    = 1'b1;
                sb_waddr = i_reg;
                sb_wdata = walk_ch;
                c_next   = ({1'b0, c_reg} < cc) ? c_reg : ct_rdata.base;
                ct_raddr = ({1'b0, c_reg} < cc) ? c_reg : ct_rdata.base;
                i_next   = i_reg - AW'(1);
                if (i_reg == '0)
                    first_next = walk_ch;
            end
            S_TAIL:
            begin
                pidx_next   = '0;
                pcount_next = n_reg;
                if (kwk_reg && n_reg < (AW+1)'(TABLE_DEPTH))
                begin
                    sb_we       = 1'b1;
                    sb_waddr    = n_reg[AW-1:0];
                    sb_wdata    = first_reg;
                    pcount_next = n_reg + (AW+1)'(1);
                end
                // new table entry
                if (!full_reg)
                begin
                    ct_we    = 1'b1;
                    ct_waddr = nf_reg[AW-1:0];
                    ct_wdata = '{base: prev_reg, ch: first_reg,
                                 len: (plen_reg >= (AW+1)'(TABLE_DEPTH)) ?
                                      (AW+1)'(TABLE_DEPTH) : plen_reg + (AW+1)'(1)};
                    nf_next  = nf_inc;
                    if (cw_inc == 4'(MAX_CODE_BITS + 1))
                    begin
                        cw_next   = 4'(MAX_CODE_BITS);
                        full_next = 1'b1;
                    end
                    else
                        cw_next = cw_inc;
                end
                prev_next = kwk_reg ? nf_reg[AW-1:0] : code_reg;
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            bb_reg     <= '0;
            bits_reg   <= '0;
            sub_reg    <= '0;
            phase_reg  <= PH_SIZE;
            root_reg   <= '0;
            cw_reg     <= '0;
            nf_reg     <= '0;
            full_reg   <= 1'b0;
            prev_reg   <= '0;
            havep_reg  <= 1'b0;
            pcount_reg <= '0;
            pidx_reg   <= '0;
            cur_reg    <= '{x: '0, y: '0, step: 4'd1};
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            bb_reg     <= bb_next;
            bits_reg   <= bits_next;
            sub_reg    <= sub_next;
            phase_reg  <= phase_next;
            root_reg   <= root_next;
            cw_reg     <= cw_next;
            nf_reg     <= nf_next;
            full_reg   <= full_next;
            prev_reg   <= prev_next;
            havep_reg  <= havep_next;
            pcount_reg <= pcount_next;
            pidx_reg   <= pidx_next;
            cur_reg    <= cur_next;
            ov_reg     <= ov_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            width_reg  <= 16'd1;
            height_reg <= 16'd1;
            interl_reg <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_LEFT:       left_reg   <= cfg.data;
                CFG_TOP:        top_reg    <= cfg.data;
                CFG_WIDTH:      width_reg  <= cfg.data;
                CFG_HEIGHT:     height_reg <= cfg.data;
                CFG_INTERLACED: interl_reg <= cfg.data[0];
                default:
                begin
                end
            endcase
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        code_reg  <= code_next;
        tgt_reg   <= tgt_next;
        kwk_reg   <= kwk_next;
        plen_reg  <= plen_next;
        n_reg     <= n_next;
        i_reg     <= i_next;
        c_reg     <= c_next;
        first_reg <= first_next;
        ost_reg   <= ost_next;
        opx_reg   <= opx_next;
        opy_reg   <= opy_next;
        oci_reg   <= oci_next;
    end

endmodule

/* rtl/glpd_ram.sv */
`timescale 1ns / 1ps
module glpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/glpd_cursor.sv */
`timescale 1ns / 1ps
module glpd_cursor import glpd_pkg::*; (
    input  cursor_t     cur,
    input  logic [15:0] left_edge,
    input  logic [15:0] top_edge,
    input  logic [15:0] image_width,
    input  logic [15:0] image_height,
    output cursor_t     nxt,
    output logic [15:0] pixel_x,
    output logic [15:0] pixel_y
);

    logic [16:0] sx;
    logic [16:0] sy;
    logic [16:0] nx;
    logic [16:0] ny;
    logic [3:0]  step;

    // screen position, saturating
    always_comb
    begin
        sx      = 17'(left_edge) + 17'(cur.x);
        sy      = 17'(top_edge) + 17'(cur.y);
        pixel_x = sx[16] ? 16'hffff : sx[15:0];
        pixel_y = sy[16] ? 16'hffff : sy[15:0];
    end

    // column step, row step and interlace pass changes
    always_comb
    begin
        nx   = 17'(cur.x) + 17'd1;
        ny   = 17'(cur.y);
        step = cur.step;
        nxt  = cur;
        if (nx < 17'(image_width))
        begin
            nxt.x = nx[15:0];
        end
        else
        begin
            nxt.x = '0;
            ny    = 17'(cur.y) + 17'(cur.step);
            if (ny >= 17'(image_height) && (cur.step == 4'd8 || cur.step == 4'd4))
            begin
                if (cur.step == 4'd8 && cur.y[2:0] == 3'd0)
                begin
                    step = 4'd8;
                    ny   = 17'd4;
                end
                else if (cur.step == 4'd8)
                begin
                    step = 4'd4;
                    ny   = 17'd2;
                end
                else
                begin
                    step = 4'd2;
                    ny   = 17'd1;
                end
                if (step == 4'd8 && ny >= 17'(image_height))
                begin
                    step = 4'd4;
                    ny   = 17'd2;
                end
                if (step == 4'd4 && ny >= 17'(image_height))
                begin
                    step = 4'd2;
                    ny   = 17'd1;
                end
            end
            nxt.step = step;
            nxt.y    = ny[16] ? 16'hffff : ny[15:0];
        end
    end

endmodule

/* rtl/glpd_checker.sv */
`timescale 1ns / 1ps
`include "gif_lzw_pixel_decoder_top_defines.svh"
module glpd_checker import glpd_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic [1:0]  req_type,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [2:0]  status,
    input logic [15:0] pixel_x,
    input logic [15:0] pixel_y,
    input logic [7:0]  color_index
);

    // a stalled result keeps its status and position
    `GLPD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(pixel_x) && $stable(pixel_y))

    // position and colour are blank unless a pixel is shown
    `GLPD_ASSERT_IMPL(a_blank, rsp_valid && status != ST_PIXEL, pixel_x == 16'd0 && pixel_y == 16'd0 && color_index == 8'd0)

    // restart answers at once
    `GLPD_ASSERT_NEXT(a_restart, req_valid && req_ready && req_type == REQ_RESTART, rsp_valid && status == ST_TAKEN)

    // unknown request is refused at once
    `GLPD_ASSERT_NEXT(a_bad_req, req_valid && req_ready && req_type == REQ_BAD, rsp_valid && status == ST_REFUSED)

    // a new transaction only when the result slot frees
    `GLPD_ASSERT_IMPL(a_slot_free, req_ready, !rsp_valid || rsp_ready)

endmodule

bind gif_lzw_pixel_decoder_top glpd_checker u_glpd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_type    (req.req_type),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .pixel_x     (rsp.pixel_x),
    .pixel_y     (rsp.pixel_y),
    .color_index (rsp.color_index)
);
